// ----- rtl/cpcr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Circle pair collision resolve package
// Shared widths, constants and transaction types for the collision core.
// ----------------------------------------------------------------------------
package cpcr_pkg;

	localparam int COORD_BITS = 20;
	localparam int RAD_BITS   = 16;
	localparam int SUM_BITS   = RAD_BITS + 1;
	localparam int REST_BITS  = 9;
	localparam int NORM_FRAC  = 16;
	localparam int REST_FRAC  = 8;
	localparam int SQ_BITS    = 2 * SUM_BITS;
	localparam int D2_BITS    = SQ_BITS + 2;
	localparam int ROOT_BITS  = D2_BITS / 2;
	localparam int REM_BITS   = ROOT_BITS + 2;
	localparam int QUOT_BITS  = NORM_FRAC + 1;
	localparam int NUM_BITS   = SUM_BITS + NORM_FRAC + 1;
	localparam int MID_DEPTH  = 4;
	localparam int OUT_DEPTH  = 2;

	localparam logic [REST_BITS-1:0] REST_RESET = 9'd205;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// Classified pair as it travels from the front end to the back end.
	typedef struct packed {
		logic                contact;
		logic                dx_neg;
		logic [SUM_BITS-1:0] adx;
		logic                dy_neg;
		logic [SUM_BITS-1:0] ady;
		logic [SUM_BITS-1:0] min_dist;
		coord_t              avx;
		coord_t              avy;
		coord_t              bvx;
		coord_t              bvy;
	} cpcr_item_t;

	typedef struct packed {
		cpcr_item_t         item;
		logic [D2_BITS-1:0] d2;
	} cpcr_mid_t;

	typedef struct packed {
		logic   contact;
		coord_t nax;
		coord_t nay;
		coord_t nbx;
		coord_t nby;
		coord_t sx;
		coord_t sy;
	} cpcr_res_t;

endpackage
`default_nettype wire

// ----- rtl/cpcr_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out buffer held in flip-flops, with full and empty flags.
// ----------------------------------------------------------------------------
module cpcr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_q;
	logic [PTR_BITS-1:0] rd_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (cnt_q == CNT_BITS'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/cpcr_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Collision front end
// Accepts circle pairs, forms the centre delta, the radius sum and the squared
// distance, and classifies each pair as touching or not.
// ----------------------------------------------------------------------------
module cpcr_front
	import cpcr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_push,
	input  wire coord_t              a_center_x,
	input  wire coord_t              a_center_y,
	input  wire coord_t              a_vel_x,
	input  wire coord_t              a_vel_y,
	input  wire logic [RAD_BITS-1:0] a_radius,
	input  wire coord_t              b_center_x,
	input  wire coord_t              b_center_y,
	input  wire coord_t              b_vel_x,
	input  wire coord_t              b_vel_y,
	input  wire logic [RAD_BITS-1:0] b_radius,
	input  wire logic                q_full,
	output logic                     q_push,
	output cpcr_mid_t                q_data
);

	localparam int DW = COORD_BITS + 1;

	logic                  adv;
	logic                  vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [DW-1:0]  dx_s1, dy_s1;
	logic [SUM_BITS-1:0]   m_s1;
	coord_t                avx_s1, avy_s1, bvx_s1, bvy_s1;
	logic [DW-1:0]         adx_w, ady_w;
	cpcr_item_t            item_s2, item_s3;
	logic [SQ_BITS-1:0]    sqx_s3, sqy_s3, m2_s3;
	logic [SQ_BITS:0]      d2_w;
	cpcr_item_t            item_w;
	cpcr_mid_t             mid_s4;

	assign adv    = !q_full;
	assign q_push = adv && vld_s4;
	assign q_data = mid_s4;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_push;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Magnitudes of the centre delta and the exact overlap test.
	always_comb begin
		adx_w = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
		ady_w = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
		d2_w  = (SQ_BITS + 1)'(sqx_s3) + (SQ_BITS + 1)'(sqy_s3);
		item_w = item_s3;
		item_w.contact = item_s3.contact && (d2_w != '0) &&
			(d2_w < (SQ_BITS + 1)'(m2_s3));
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: delta and radius sum.
			dx_s1  <= DW'(b_center_x) - DW'(a_center_x);
			dy_s1  <= DW'(b_center_y) - DW'(a_center_y);
			m_s1   <= SUM_BITS'(a_radius) + SUM_BITS'(b_radius);
			avx_s1 <= a_vel_x;
			avy_s1 <= a_vel_y;
			bvx_s1 <= b_vel_x;
			bvy_s1 <= b_vel_y;

			// Stage 2: coarse box check on each axis.
			item_s2.contact  <= (adx_w < DW'(m_s1)) && (ady_w < DW'(m_s1));
			item_s2.dx_neg   <= dx_s1[DW-1];
			item_s2.adx      <= adx_w[SUM_BITS-1:0];
			item_s2.dy_neg   <= dy_s1[DW-1];
			item_s2.ady      <= ady_w[SUM_BITS-1:0];
			item_s2.min_dist <= m_s1;
			item_s2.avx      <= avx_s1;
			item_s2.avy      <= avy_s1;
			item_s2.bvx      <= bvx_s1;
			item_s2.bvy      <= bvy_s1;

			// Stage 3: squares.
			item_s3 <= item_s2;
			sqx_s3  <= item_s2.adx * item_s2.adx;
			sqy_s3  <= item_s2.ady * item_s2.ady;
			m2_s3   <= item_s2.min_dist * item_s2.min_dist;

			// Stage 4: exact overlap test on squared distances.
			mid_s4.item <= item_w;
			mid_s4.d2   <= D2_BITS'(d2_w);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/cpcr_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Collision back end
// Pipelined square root and normal division, then the relative normal
// velocity, the equal-mass impulse and the position correction.
// ----------------------------------------------------------------------------
module cpcr_back
	import cpcr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [REST_BITS-1:0] restitution,
	input  wire cpcr_mid_t            q_data,
	input  wire logic                 q_empty,
	output logic                      q_pop,
	input  wire logic                 res_full,
	output logic                      res_push,
	output cpcr_res_t                 res_data
);

	localparam int POST   = 7;
	localparam int NSTAGE = ROOT_BITS + QUOT_BITS + POST;
	localparam int DW     = COORD_BITS + 1;
	localparam int NW     = QUOT_BITS + 1;
	localparam int PW     = DW + NW;
	localparam int VW     = PW + 1;
	localparam int KW     = REST_BITS + 1;
	localparam int JXW    = VW + KW;
	localparam int JW     = JXW - (NORM_FRAC + REST_FRAC + 1) + 1;
	localparam int IMW    = JW + QUOT_BITS;
	localparam int IW     = IMW - NORM_FRAC + 1;
	localparam int PNW    = SUM_BITS + QUOT_BITS;
	localparam int SMW    = PNW - NORM_FRAC;
	localparam int SUMW   = IW + 2;

	localparam logic [JXW:0]   J_HALF  = (JXW + 1)'(1) << (NORM_FRAC + REST_FRAC);
	localparam logic [IMW:0]   I_HALF  = (IMW + 1)'(1) << (NORM_FRAC - 1);
	localparam logic [PNW:0]   S_HALF  = (PNW + 1)'(1) << NORM_FRAC;

	logic               adv;
	logic [NSTAGE-1:0]  vld_s;

	// Square root stages.
	cpcr_item_t            sq_item_s [ROOT_BITS];
	logic [REM_BITS-1:0]   sq_rem_s  [ROOT_BITS];
	logic [ROOT_BITS-1:0]  sq_root_s [ROOT_BITS];
	logic [D2_BITS-1:0]    sq_rad_s  [ROOT_BITS];

	// Division stages.
	cpcr_item_t            dv_item_s [QUOT_BITS];
	logic [SUM_BITS-1:0]   dv_dist_s [QUOT_BITS];
	logic [NUM_BITS-1:0]   dv_rx_s   [QUOT_BITS];
	logic [NUM_BITS-1:0]   dv_ry_s   [QUOT_BITS];
	logic [QUOT_BITS-1:0]  dv_qx_s   [QUOT_BITS];
	logic [QUOT_BITS-1:0]  dv_qy_s   [QUOT_BITS];

	// Post stages.
	cpcr_item_t              it_s1, it_s2, it_s3, it_s4, it_s5, it_s6, it_s7;
	logic [QUOT_BITS-1:0]    qx_s1, qy_s1, qx_s2, qy_s2, qx_s3, qy_s3;
	logic [QUOT_BITS-1:0]    qx_s4, qy_s4, qx_s5, qy_s5;
	logic signed [NW-1:0]    nxs_s1, nys_s1;
	logic signed [DW-1:0]    dvx_s1, dvy_s1;
	logic [SUM_BITS-1:0]     pen_s1;
	logic signed [PW-1:0]    pvx_s2, pvy_s2;
	logic [PNW-1:0]          penx_s2, peny_s2;
	logic signed [VW-1:0]    vn_s3;
	coord_t                  sx_s3, sy_s3, sx_s4, sy_s4, sx_s5, sy_s5;
	coord_t                  sx_s6, sy_s6, sx_s7, sy_s7;
	logic [JXW-1:0]          jx_s4;
	logic                    app_s4;
	logic [JW-1:0]           j_s5;
	logic [IMW-1:0]          ixm_s6, iym_s6;
	logic signed [IW-1:0]    ix_s7, iy_s7;

	// Combinational helpers for the post stages.
	logic [SMW-1:0]  sxm_w, sym_w;
	logic [VW-1:0]   vmag_w;
	logic [KW-1:0]   kmul_w;
	logic [JXW:0]    jsum_w;
	logic [IMW:0]    ixs_w, iys_w;
	logic [IW-2:0]   ixm_w, iym_w;
	logic [PNW:0]    sxs_w, sys_w;

	function automatic coord_t sat_coord(input logic signed [SUMW-1:0] v);
		logic [SUMW-COORD_BITS:0] top;
		top = v[SUMW-1:COORD_BITS-1];
		if ((&top) || !(|top)) begin
			sat_coord = v[COORD_BITS-1:0];
		end else if (v[SUMW-1]) begin
			sat_coord = {1'b1, {(COORD_BITS - 1){1'b0}}};
		end else begin
			sat_coord = {1'b0, {(COORD_BITS - 1){1'b1}}};
		end
	endfunction

	assign adv      = !res_full;
	assign q_pop    = adv && !q_empty;
	assign res_push = adv && vld_s[NSTAGE-1];

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTAGE-2:0], q_pop};
		end
	end

	// Integer square root, one root bit per stage.
	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
		cpcr_item_t           item_in;
		logic [REM_BITS-1:0]  rem_in, rem_sh, trial;
		logic [ROOT_BITS-1:0] root_in;
		logic [D2_BITS-1:0]   rad_in;

		if (k == 0) begin : g_first
			assign item_in = q_data.item;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = q_data.d2;
		end else begin : g_next
			assign item_in = sq_item_s[k-1];
			assign rem_in  = sq_rem_s[k-1];
			assign root_in = sq_root_s[k-1];
			assign rad_in  = sq_rad_s[k-1];
		end

		assign rem_sh = {rem_in[REM_BITS-3:0], rad_in[D2_BITS-1 -: 2]};
		assign trial  = {root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_item_s[k] <= item_in;
				sq_rad_s[k]  <= rad_in << 2;
				if (rem_sh >= trial) begin
					sq_rem_s[k]  <= rem_sh - trial;
					sq_root_s[k] <= {root_in[ROOT_BITS-2:0], 1'b1};
				end else begin
					sq_rem_s[k]  <= rem_sh;
					sq_root_s[k] <= {root_in[ROOT_BITS-2:0], 1'b0};
				end
			end
		end
	end

	// Rounded normal division, one quotient bit per stage on each axis.
	for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
		localparam int SH = QUOT_BITS - 1 - k;
		cpcr_item_t           item_in;
		logic [SUM_BITS-1:0]  dist_in;
		logic [NUM_BITS-1:0]  rx_in, ry_in, dsh;
		logic [QUOT_BITS-1:0] qx_in, qy_in;

		if (k == 0) begin : g_first
			assign item_in = sq_item_s[ROOT_BITS-1];
			assign dist_in = sq_root_s[ROOT_BITS-1][SUM_BITS-1:0];
			assign rx_in   = NUM_BITS'({item_in.adx, {NORM_FRAC{1'b0}}}) +
				NUM_BITS'(dist_in >> 1);
			assign ry_in   = NUM_BITS'({item_in.ady, {NORM_FRAC{1'b0}}}) +
				NUM_BITS'(dist_in >> 1);
			assign qx_in   = '0;
			assign qy_in   = '0;
		end else begin : g_next
			assign item_in = dv_item_s[k-1];
			assign dist_in = dv_dist_s[k-1];
			assign rx_in   = dv_rx_s[k-1];
			assign ry_in   = dv_ry_s[k-1];
			assign qx_in   = dv_qx_s[k-1];
			assign qy_in   = dv_qy_s[k-1];
		end

		assign dsh = NUM_BITS'(dist_in) << SH;

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_item_s[k] <= item_in;
				dv_dist_s[k] <= dist_in;
				if (rx_in >= dsh) begin
					dv_rx_s[k] <= rx_in - dsh;
					dv_qx_s[k] <= qx_in | (QUOT_BITS'(1) << SH);
				end else begin
					dv_rx_s[k] <= rx_in;
					dv_qx_s[k] <= qx_in;
				end
				if (ry_in >= dsh) begin
					dv_ry_s[k] <= ry_in - dsh;
					dv_qy_s[k] <= qy_in | (QUOT_BITS'(1) << SH);
				end else begin
					dv_ry_s[k] <= ry_in;
					dv_qy_s[k] <= qy_in;
				end
			end
		end
	end

	// Rounding and scaling terms between post stages.
	always_comb begin
		sxs_w  = (PNW + 1)'(penx_s2) + S_HALF;
		sys_w  = (PNW + 1)'(peny_s2) + S_HALF;
		sxm_w  = sxs_w[PNW:NORM_FRAC + 1];
		sym_w  = sys_w[PNW:NORM_FRAC + 1];
		vmag_w = VW'(-vn_s3);
		kmul_w = KW'(restitution) + KW'(1 << REST_FRAC);
		jsum_w = (JXW + 1)'(jx_s4) + J_HALF;
		ixs_w  = (IMW + 1)'(ixm_s6) + I_HALF;
		iys_w  = (IMW + 1)'(iym_s6) + I_HALF;
		ixm_w  = ixs_w[IMW-1:NORM_FRAC];
		iym_w  = iys_w[IMW-1:NORM_FRAC];
	end

	// Post stages: normal, products, impulse and correction.
	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1: signed normal, relative velocity, penetration.
			it_s1  <= dv_item_s[QUOT_BITS-1];
			qx_s1  <= dv_qx_s[QUOT_BITS-1];
			qy_s1  <= dv_qy_s[QUOT_BITS-1];
			nxs_s1 <= dv_item_s[QUOT_BITS-1].dx_neg ?
				-$signed({1'b0, dv_qx_s[QUOT_BITS-1]}) : $signed({1'b0, dv_qx_s[QUOT_BITS-1]});
			nys_s1 <= dv_item_s[QUOT_BITS-1].dy_neg ?
				-$signed({1'b0, dv_qy_s[QUOT_BITS-1]}) : $signed({1'b0, dv_qy_s[QUOT_BITS-1]});
			dvx_s1 <= DW'(dv_item_s[QUOT_BITS-1].bvx) - DW'(dv_item_s[QUOT_BITS-1].avx);
			dvy_s1 <= DW'(dv_item_s[QUOT_BITS-1].bvy) - DW'(dv_item_s[QUOT_BITS-1].avy);
			pen_s1 <= dv_item_s[QUOT_BITS-1].min_dist - dv_dist_s[QUOT_BITS-1];

			// Stage 2: normal velocity products and correction products.
			it_s2   <= it_s1;
			qx_s2   <= qx_s1;
			qy_s2   <= qy_s1;
			pvx_s2  <= dvx_s1 * nxs_s1;
			pvy_s2  <= dvy_s1 * nys_s1;
			penx_s2 <= pen_s1 * qx_s1;
			peny_s2 <= pen_s1 * qy_s1;

			// Stage 3: normal velocity and half penetration along the normal.
			it_s3 <= it_s2;
			qx_s3 <= qx_s2;
			qy_s3 <= qy_s2;
			vn_s3 <= VW'(pvx_s2) + VW'(pvy_s2);
			sx_s3 <= it_s2.dx_neg ? -$signed(COORD_BITS'(sxm_w)) : $signed(COORD_BITS'(sxm_w));
			sy_s3 <= it_s2.dy_neg ? -$signed(COORD_BITS'(sym_w)) : $signed(COORD_BITS'(sym_w));

			// Stage 4: scale the approach speed by one plus restitution.
			it_s4  <= it_s3;
			qx_s4  <= qx_s3;
			qy_s4  <= qy_s3;
			sx_s4  <= sx_s3;
			sy_s4  <= sy_s3;
			app_s4 <= it_s3.contact && vn_s3[VW-1];
			jx_s4  <= vmag_w * kmul_w;

			// Stage 5: round the impulse magnitude.
			it_s5 <= it_s4;
			qx_s5 <= qx_s4;
			qy_s5 <= qy_s4;
			sx_s5 <= sx_s4;
			sy_s5 <= sy_s4;
			j_s5  <= app_s4 ? jsum_w[JXW:NORM_FRAC + REST_FRAC + 1] : '0;

			// Stage 6: impulse along the normal.
			it_s6  <= it_s5;
			sx_s6  <= sx_s5;
			sy_s6  <= sy_s5;
			ixm_s6 <= j_s5 * qx_s5;
			iym_s6 <= j_s5 * qy_s5;

			// Stage 7: round and sign the impulse components.
			it_s7 <= it_s6;
			sx_s7 <= sx_s6;
			sy_s7 <= sy_s6;
			ix_s7 <= it_s6.dx_neg ? -$signed({1'b0, ixm_w}) : $signed({1'b0, ixm_w});
			iy_s7 <= it_s6.dy_neg ? -$signed({1'b0, iym_w}) : $signed({1'b0, iym_w});
		end
	end

	// Apply the impulse with saturation.
	always_comb begin
		res_data.contact = it_s7.contact;
		res_data.nax     = sat_coord(SUMW'(it_s7.avx) - SUMW'(ix_s7));
		res_data.nay     = sat_coord(SUMW'(it_s7.avy) - SUMW'(iy_s7));
		res_data.nbx     = sat_coord(SUMW'(it_s7.bvx) + SUMW'(ix_s7));
		res_data.nby     = sat_coord(SUMW'(it_s7.bvy) + SUMW'(iy_s7));
		res_data.sx      = it_s7.contact ? sx_s7 : '0;
		res_data.sy      = it_s7.contact ? sy_s7 : '0;
	end

endmodule
`default_nettype wire

// ----- rtl/circle_pair_collision_resolve_core.sv -----
`default_nettype none
// Structure: an accepted pair passes through 4 front stages, 18 root stages,
// 17 divide stages and 7 impulse stages, plus the two queues, before its result
// reaches the output queue.
// Throughput: one pair per cycle; the front end stalls only while the middle
// queue is full and the back end only while the output queue is full. Reset
// clears all queues and valid bits and sets restitution to 205.
// ----------------------------------------------------------------------------
// Circle pair collision resolve core
// Equal-mass circle collision response with restitution and a position fix.
// ----------------------------------------------------------------------------
module circle_pair_collision_resolve_core
	import cpcr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire coord_t               a_center_x,
	input  wire coord_t               a_center_y,
	input  wire coord_t               a_vel_x,
	input  wire coord_t               a_vel_y,
	input  wire logic [RAD_BITS-1:0]  a_radius,
	input  wire coord_t               b_center_x,
	input  wire coord_t               b_center_y,
	input  wire coord_t               b_vel_x,
	input  wire coord_t               b_vel_y,
	input  wire logic [RAD_BITS-1:0]  b_radius,
	input  wire logic                 pop,
	output logic                      empty,
	output logic                      contact,
	output coord_t                    new_a_vel_x,
	output coord_t                    new_a_vel_y,
	output coord_t                    new_b_vel_x,
	output coord_t                    new_b_vel_y,
	output coord_t                    shift_x,
	output coord_t                    shift_y,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [REST_BITS-1:0] cfg_restitution
);

	logic [REST_BITS-1:0] rest_q;
	logic                 mid_push, mid_full, mid_pop, mid_empty;
	cpcr_mid_t            mid_wdata, mid_rdata;
	logic                 res_push, res_full;
	cpcr_res_t            res_wdata, res_rdata;

	// Restitution register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= REST_RESET;
		end else if (cfg_valid) begin
			rest_q <= cfg_restitution;
		end
	end

	assign full = mid_full;

	cpcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_push    (push),
		.a_center_x (a_center_x),
		.a_center_y (a_center_y),
		.a_vel_x    (a_vel_x),
		.a_vel_y    (a_vel_y),
		.a_radius   (a_radius),
		.b_center_x (b_center_x),
		.b_center_y (b_center_y),
		.b_vel_x    (b_vel_x),
		.b_vel_y    (b_vel_y),
		.b_radius   (b_radius),
		.q_full     (mid_full),
		.q_push     (mid_push),
		.q_data     (mid_wdata)
	);

	// Queue between the front end and the back end.
	cpcr_fifo #(
		.WIDTH ($bits(cpcr_mid_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	cpcr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.restitution (rest_q),
		.q_data      (mid_rdata),
		.q_empty     (mid_empty),
		.q_pop       (mid_pop),
		.res_full    (res_full),
		.res_push    (res_push),
		.res_data    (res_wdata)
	);

	// Result queue toward the consumer.
	cpcr_fifo #(
		.WIDTH ($bits(cpcr_res_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign contact     = res_rdata.contact;
	assign new_a_vel_x = res_rdata.nax;
	assign new_a_vel_y = res_rdata.nay;
	assign new_b_vel_x = res_rdata.nbx;
	assign new_b_vel_y = res_rdata.nby;
	assign shift_x     = res_rdata.sx;
	assign shift_y     = res_rdata.sy;

endmodule
`default_nettype wire
